[rtl/core/radial_stick_deadzone_unit_defines.svh]
// ---------------------------------------------------------------------------
// radial_stick_deadzone_unit_defines
// assertion macros shared by the dead zone block
// ---------------------------------------------------------------------------
`ifndef RADIAL_STICK_DEADZONE_UNIT_DEFINES_SVH
`define RADIAL_STICK_DEADZONE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSD_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RSD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// implication that also runs through reset
`define RSD_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/rsd_pkg.sv]
// ---------------------------------------------------------------------------
// rsd_pkg
// constants for the radial stick dead zone block
// ---------------------------------------------------------------------------
package rsd_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RAD_W           = 15;
  localparam int NRM_W           = 17;
  localparam int QO_W            = 15;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = 15'd7849;
  localparam logic [NRM_W-1:0]  NORM_ONE     = 17'd65536;
  localparam logic [QO_W-1:0]   OUT_MAX      = 15'd32767;
  localparam logic [ADDR_W-1:0] REG_RADIUS   = 3'd0;
endpackage

[rtl/core/radial_stick_deadzone_unit.sv]
// ---------------------------------------------------------------------------
// radial_stick_deadzone_unit
// circular stick dead zone with radial rescale, fully pipelined
// ---------------------------------------------------------------------------
// Takes one signed stick pair per cycle when not stalled and returns one
// conditioned pair per beat. Samples whose squared length is zero or under
// dead_radius squared come out as zero with in_dead_zone set; all others get
// length mag (square root with 8 fraction bits), normalized travel
// min((mag-r)/(full-r),1) with 16 fraction bits, and each axis becomes
// axis*norm/mag in Q1.15, truncated and saturated to +-32767. The pipe holds
// the bit-per-stage square root (SAMPLE_BITS+8 stages), the 17-stage normalize
// divider and the 15-stage axis dividers. The whole pipe moves when the output
// register is empty or taken, so in_stall follows out_stall only while a
// result is held. dead_radius is written over APB at addresses 0 to 3; the user
// writes it only while idle, which the block does not enforce.
// ---------------------------------------------------------------------------
`include "radial_stick_deadzone_unit_defines.svh"

module radial_stick_deadzone_unit #(
  parameter int SAMPLE_BITS = rsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         raw_x,
  input  logic signed [15:0]         raw_y,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [15:0]         out_x,
  output logic signed [15:0]         out_y,
  output logic                       in_dead_zone,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsd_pkg::ADDR_W-1:0] paddr,
  input  logic [rsd_pkg::DATA_W-1:0] pwdata,
  output logic [rsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int SW    = SAMPLE_BITS;
  localparam int SQ_W  = 2 * SW;          // x*x + y*y
  localparam int MAG_W = SW + 8;          // length with 8 fraction bits
  localparam int N_W   = 2 * MAG_W;       // radicand sum << 16
  localparam int E_W   = SW - 1;          // full - r
  localparam int NUM_W = MAG_W + 8;       // normalize dividend
  localparam int NRM_W = rsd_pkg::NRM_W;
  localparam int QO_W  = rsd_pkg::QO_W;
  localparam int P_W   = SW + NRM_W;      // |axis| * norm
  localparam int R_W   = P_W + 7;         // axis dividend
  localparam int RAD_W = rsd_pkg::RAD_W;
  localparam int FULL  = (1 << (SW - 1)) - 1;

  typedef struct packed {
    logic [SW-1:0] ax;
    logic [SW-1:0] ay;
    logic          nx;
    logic          ny;
    logic          dead;
  } side_t;

  // ---- configuration register
  logic [RAD_W-1:0]   dead_radius;
  logic [2*RAD_W-1:0] rad_sq;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[rsd_pkg::ADDR_W-1] == 1'b0);
  assign prdata = (paddr == rsd_pkg::REG_RADIUS)
                  ? {{(rsd_pkg::DATA_W-RAD_W){1'b0}}, dead_radius} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_radius <= rsd_pkg::RADIUS_RESET;
    end else if (cfg_wr) begin
      dead_radius <= pwdata[RAD_W-1:0];
    end
    // radius squared settles long before any sample once configuration is idle
    rad_sq <= (2*RAD_W)'(dead_radius) * (2*RAD_W)'(dead_radius);
  end

  // ---- pipe advance: whole pipe moves unless a held result is stalled
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---- stage 1: low SAMPLE_BITS bits, magnitude, squares
  logic [SW-1:0]   sx, sy;
  logic [SW-1:0]   ax_c, ay_c;
  logic            v1;
  logic [SQ_W-1:0] sqx1, sqy1;
  side_t           sd1;

  assign sx   = raw_x[SW-1:0];
  assign sy   = raw_y[SW-1:0];
  assign ax_c = sx[SW-1] ? (~sx + 1'b1) : sx;
  assign ay_c = sy[SW-1] ? (~sy + 1'b1) : sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      sqx1    <= SQ_W'(ax_c) * SQ_W'(ax_c);
      sqy1    <= SQ_W'(ay_c) * SQ_W'(ay_c);
      sd1.ax  <= ax_c;
      sd1.ay  <= ay_c;
      sd1.nx  <= sx[SW-1];
      sd1.ny  <= sy[SW-1];
      sd1.dead <= 1'b0;
    end
  end

  // ---- stage 2: squared length, dead zone test; feeds square root stage 0
  logic [SQ_W-1:0] sum_c;
  logic            dead_c;
  side_t           sd2_c;
  logic [N_W-1:0]  sq_n   [0:MAG_W];
  logic [N_W-1:0]  sq_res [0:MAG_W];
  side_t           sq_sd  [0:MAG_W];
  logic            sq_v   [0:MAG_W];

  assign sum_c  = sqx1 + sqy1;
  assign dead_c = (sum_c == '0) ||
                  ({{(2*RAD_W+SQ_W){1'b0}}, sum_c} <
                   {{(SQ_W+SQ_W){1'b0}}, rad_sq});

  // side info with the dead zone flag filled in
  always_comb begin
    sd2_c      = sd1;
    sd2_c.dead = dead_c;
  end

  // ---- square root, one result bit per stage
  logic [N_W-1:0] sq_n_next   [0:MAG_W-1];
  logic [N_W-1:0] sq_res_next [0:MAG_W-1];

  always_comb begin
    logic [N_W-1:0] bitk;
    logic [N_W-1:0] trial;
    for (int k = 0; k < MAG_W; k++) begin
      bitk  = N_W'(1) << (2 * (MAG_W - 1 - k));
      trial = sq_res[k] + bitk;
      if (sq_n[k] >= trial) begin
        sq_n_next[k]   = sq_n[k] - trial;
        sq_res_next[k] = (sq_res[k] >> 1) + bitk;
      end else begin
        sq_n_next[k]   = sq_n[k];
        sq_res_next[k] = sq_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MAG_W; k++) sq_v[k] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= v1;
      for (int k = 0; k < MAG_W; k++) sq_v[k+1] <= sq_v[k];
    end
    if (adv) begin
      sq_n[0]          <= {sum_c, 16'b0};
      sq_res[0]        <= '0;
      sq_sd[0]         <= sd2_c;
      for (int k = 0; k < MAG_W; k++) begin
        sq_n[k+1]   <= sq_n_next[k];
        sq_res[k+1] <= sq_res_next[k];
        sq_sd[k+1]  <= sq_sd[k];
      end
    end
  end

  // ---- normalize setup: travel past the rim over travel available
  logic [MAG_W-1:0] mag_c;
  logic [MAG_W-1:0] trav_c;
  logic [E_W-1:0]   span_c;
  logic             full_c, big_c;

  assign mag_c  = sq_res[MAG_W][MAG_W-1:0];
  assign trav_c = MAG_W'(mag_c - {{(MAG_W){1'b0}}, dead_radius, 8'b0});
  assign span_c = E_W'(32'(FULL) - {{(32-RAD_W){1'b0}}, dead_radius});
  assign full_c = {{(32-RAD_W){1'b0}}, dead_radius} >= 32'(FULL);
  assign big_c  = trav_c >= {span_c, 9'b0};

  // ---- normalize divider, 17 quotient bits
  logic [NUM_W-1:0] nd_rem   [0:NRM_W];
  logic [NRM_W-1:0] nd_q     [0:NRM_W];
  logic [E_W-1:0]   nd_den   [0:NRM_W];
  logic             nd_clamp [0:NRM_W];
  logic [MAG_W-1:0] nd_mag   [0:NRM_W];
  side_t            nd_sd    [0:NRM_W];
  logic             nd_v     [0:NRM_W];
  logic [NUM_W-1:0] nd_rem_next [0:NRM_W-1];
  logic [NRM_W-1:0] nd_q_next   [0:NRM_W-1];

  always_comb begin
    logic [NUM_W-1:0] sh;
    for (int j = 0; j < NRM_W; j++) begin
      sh = {{(NUM_W-E_W){1'b0}}, nd_den[j]} << (NRM_W - 1 - j);
      if (nd_rem[j] >= sh) begin
        nd_rem_next[j] = nd_rem[j] - sh;
        nd_q_next[j]   = nd_q[j] | (NRM_W'(1) << (NRM_W - 1 - j));
      end else begin
        nd_rem_next[j] = nd_rem[j];
        nd_q_next[j]   = nd_q[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NRM_W; j++) nd_v[j] <= 1'b0;
    end else if (adv) begin
      nd_v[0] <= sq_v[MAG_W];
      for (int j = 0; j < NRM_W; j++) nd_v[j+1] <= nd_v[j];
    end
    if (adv) begin
      nd_rem[0]   <= {trav_c, 8'b0};
      nd_q[0]     <= '0;
      nd_den[0]   <= span_c;
      nd_clamp[0] <= full_c || big_c;
      nd_mag[0]   <= mag_c;
      nd_sd[0]    <= sq_sd[MAG_W];
      for (int j = 0; j < NRM_W; j++) begin
        nd_rem[j+1]   <= nd_rem_next[j];
        nd_q[j+1]     <= nd_q_next[j];
        nd_den[j+1]   <= nd_den[j];
        nd_clamp[j+1] <= nd_clamp[j];
        nd_mag[j+1]   <= nd_mag[j];
        nd_sd[j+1]    <= nd_sd[j];
      end
    end
  end

  // ---- product stage: |axis| * norm
  logic [NRM_W-1:0] norm_c;
  logic [P_W-1:0]   pr_px, pr_py;
  logic [MAG_W-1:0] pr_mag;
  side_t            pr_sd;
  logic             pr_v;

  assign norm_c = (nd_clamp[NRM_W] || (nd_q[NRM_W] > rsd_pkg::NORM_ONE))
                  ? rsd_pkg::NORM_ONE : nd_q[NRM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else if (adv) begin
      pr_v <= nd_v[NRM_W];
    end
    if (adv) begin
      pr_px  <= {{NRM_W{1'b0}}, nd_sd[NRM_W].ax} * {{SW{1'b0}}, norm_c};
      pr_py  <= {{NRM_W{1'b0}}, nd_sd[NRM_W].ay} * {{SW{1'b0}}, norm_c};
      pr_mag <= nd_mag[NRM_W];
      pr_sd  <= nd_sd[NRM_W];
    end
  end

  // ---- axis dividers, 15 quotient bits each, saturation flagged up front
  logic [R_W-1:0]   ad_rx  [0:QO_W];
  logic [R_W-1:0]   ad_ry  [0:QO_W];
  logic [QO_W-1:0]  ad_qx  [0:QO_W];
  logic [QO_W-1:0]  ad_qy  [0:QO_W];
  logic             ad_ox  [0:QO_W];
  logic             ad_oy  [0:QO_W];
  logic [MAG_W-1:0] ad_mag [0:QO_W];
  side_t            ad_sd  [0:QO_W];
  logic             ad_v   [0:QO_W];
  logic [R_W-1:0]   ad_rx_next [0:QO_W-1];
  logic [R_W-1:0]   ad_ry_next [0:QO_W-1];
  logic [QO_W-1:0]  ad_qx_next [0:QO_W-1];
  logic [QO_W-1:0]  ad_qy_next [0:QO_W-1];
  logic [P_W-1:0]   sat_lim;

  assign sat_lim = {{(P_W-MAG_W-8){1'b0}}, pr_mag, 8'b0};

  always_comb begin
    logic [R_W-1:0]  sh;
    logic [QO_W-1:0] qb;
    for (int j = 0; j < QO_W; j++) begin
      sh = {{(R_W-MAG_W){1'b0}}, ad_mag[j]} << (QO_W - 1 - j);
      qb = QO_W'(1) << (QO_W - 1 - j);
      if (ad_rx[j] >= sh) begin
        ad_rx_next[j] = ad_rx[j] - sh;
        ad_qx_next[j] = ad_qx[j] | qb;
      end else begin
        ad_rx_next[j] = ad_rx[j];
        ad_qx_next[j] = ad_qx[j];
      end
      if (ad_ry[j] >= sh) begin
        ad_ry_next[j] = ad_ry[j] - sh;
        ad_qy_next[j] = ad_qy[j] | qb;
      end else begin
        ad_ry_next[j] = ad_ry[j];
        ad_qy_next[j] = ad_qy[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QO_W; j++) ad_v[j] <= 1'b0;
    end else if (adv) begin
      ad_v[0] <= pr_v;
      for (int j = 0; j < QO_W; j++) ad_v[j+1] <= ad_v[j];
    end
    if (adv) begin
      ad_rx[0]  <= {pr_px, 7'b0};
      ad_ry[0]  <= {pr_py, 7'b0};
      ad_qx[0]  <= '0;
      ad_qy[0]  <= '0;
      ad_ox[0]  <= pr_px >= sat_lim;
      ad_oy[0]  <= pr_py >= sat_lim;
      ad_mag[0] <= pr_mag;
      ad_sd[0]  <= pr_sd;
      for (int j = 0; j < QO_W; j++) begin
        ad_rx[j+1]  <= ad_rx_next[j];
        ad_ry[j+1]  <= ad_ry_next[j];
        ad_qx[j+1]  <= ad_qx_next[j];
        ad_qy[j+1]  <= ad_qy_next[j];
        ad_ox[j+1]  <= ad_ox[j];
        ad_oy[j+1]  <= ad_oy[j];
        ad_mag[j+1] <= ad_mag[j];
        ad_sd[j+1]  <= ad_sd[j];
      end
    end
  end

  // ---- output register: saturate, restore sign, zero the dead zone
  logic [QO_W-1:0] qx_c, qy_c;
  logic [15:0]     ox_c, oy_c;
  side_t           fin_sd;

  assign fin_sd = ad_sd[QO_W];
  assign qx_c   = ad_ox[QO_W] ? rsd_pkg::OUT_MAX : ad_qx[QO_W];
  assign qy_c   = ad_oy[QO_W] ? rsd_pkg::OUT_MAX : ad_qy[QO_W];
  assign ox_c   = fin_sd.dead ? 16'd0
                : (fin_sd.nx ? (16'd0 - {1'b0, qx_c}) : {1'b0, qx_c});
  assign oy_c   = fin_sd.dead ? 16'd0
                : (fin_sd.ny ? (16'd0 - {1'b0, qy_c}) : {1'b0, qy_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ad_v[QO_W];
    end
    if (adv) begin
      out_x        <= ox_c;
      out_y        <= oy_c;
      in_dead_zone <= fin_sd.dead;
    end
  end

  // ---- checks
  `RSD_ASSERT_NOW(a_dead_zero, clk, rst, out_valid && in_dead_zone, (out_x == 16'sd0) && (out_y == 16'sd0), "dead zone beat with nonzero axis")
  `RSD_ASSERT_NOW(a_sat_range, clk, rst, out_valid, (out_x != 16'sh8000) && (out_y != 16'sh8000), "axis beyond saturation range")
  `RSD_ASSERT_ALWAYS(a_rst_empty, clk, $past(rst), !out_valid, "result valid right after reset")
  `RSD_ASSERT_NEXT(a_held_beat, clk, rst, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(in_dead_zone), "stalled result moved or dropped")

endmodule
